// ===== hw/rtl/rbps_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes, types and helper functions for the ready-bitmap scheduler.
// Depends on nothing; every other file of the block imports it.
package rbps_pkg;

   // Geometry of the two-level ready map.
   localparam int ROW_WIDTH = 16;
   localparam int ROW_IDX_W = $clog2(ROW_WIDTH);
   localparam int NUM_SLOTS = ROW_WIDTH * ROW_WIDTH;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);

   // Fixed field widths.
   localparam int PRIO_W   = 8;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [PRIO_W-1:0]   prio_type;
   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [ROW_IDX_W-1:0] row_idx_type;
   typedef logic [ROW_WIDTH-1:0] row_bits_type;

   // Operation codes.
   localparam op_type OP_CREATE = 3'd0;
   localparam op_type OP_RESUME = 3'd1;
   localparam op_type OP_PEND   = 3'd2;
   localparam op_type OP_DELETE = 3'd3;
   localparam op_type OP_CHECK  = 3'd4;

   // Status codes.
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_TAKEN = 2'd1;
   localparam status_type ST_NONE  = 2'd2;

   // Update request from the decoder to the ready map.
   typedef struct packed {
      logic set_ready;
      logic clr_ready;
      logic set_used;
      logic clr_used;
   } map_ctrl_type;

   // Index of the lowest set bit of a row-wide vector, zero when none is set.
   function automatic row_idx_type lowest_set(input row_bits_type bits);
      row_idx_type idx;
      idx = '0;
      for (int i = ROW_WIDTH - 1; i >= 0; i--) begin
         if (bits[i]) begin
            idx = row_idx_type'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== hw/rtl/ready_bitmap_priority_scheduler.sv =====
`timescale 1ns / 1ps
// Top level of the two-level ready-bitmap priority scheduler: handshakes,
// input and result registers. Depends on rbps_pkg, rbps_decode and rbps_ready_map.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  operation, target_prio, target_self,
//                                              current_prio
//   rsp      out        rsp_valid / rsp_stall  status, reschedule, highest_prio,
//                                              any_ready
//   csr      in         csr_wr_en              os_running (csr_wr_data)
//
// An accepted item is held in the input register; the decoder and ready map then
// work on it combinationally and the result register captures the answer as the
// item advances, which a held rsp_stall can delay; one item per cycle is
// sustained while rsp_stall is low.
// That rate is set by the single path from the input register through the map
// update and two-level priority encode into the result register.
// Reset clears the slot flags, the ready bitmap, os_running and both valid flags.
// When rsp_stall holds a result, the input register keeps one more item; with
// both full, req_stall rises.
module ready_bitmap_priority_scheduler (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rbps_pkg::op_type     req_operation,
   input  rbps_pkg::prio_type   req_target_prio,
   input  logic                 req_target_self,
   input  rbps_pkg::prio_type   req_current_prio,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rbps_pkg::status_type rsp_status,
   output logic                 rsp_reschedule,
   output rbps_pkg::prio_type   rsp_highest_prio,
   output logic                 rsp_any_ready,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data
);
   import rbps_pkg::*;

   // Configuration register.
   logic os_running_ff;

   // Input register. The target slot is resolved from target_self on the way in.
   logic     s1_valid_ff;
   logic     s1_valid_in;
   op_type   s1_op_ff;
   prio_type s1_prio_ff;
   prio_type s1_cur_ff;

   // Result register.
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   status_type rsp_status_ff;
   logic       rsp_resched_ff;
   prio_type   rsp_high_ff;
   logic       rsp_any_ff;

   logic         req_accept;
   logic         advance;
   slot_type     slot;
   map_ctrl_type ctrl;
   map_ctrl_type ctrl_gated;
   logic         slot_used;
   prio_type     highest_prio;
   logic         any_ready;
   status_type   status;
   logic         reschedule;

   // The item in the input register moves on whenever the result register is
   // free or is being emptied this cycle.
   assign advance    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   rbps_decode u_decode (
      .operation    (s1_op_ff),
      .prio         (s1_prio_ff),
      .current_prio (s1_cur_ff),
      .os_running   (os_running_ff),
      .slot_used    (slot_used),
      .highest_prio (highest_prio),
      .any_ready    (any_ready),
      .slot         (slot),
      .ctrl         (ctrl),
      .status       (status),
      .reschedule   (reschedule)
   );

   // Only an item that actually leaves the input register may change the map.
   assign ctrl_gated = s1_valid_ff ? ctrl : '0;

   rbps_ready_map u_ready_map (
      .clock        (clock),
      .reset        (reset),
      .commit       (advance),
      .slot         (slot),
      .ctrl         (ctrl_gated),
      .slot_used    (slot_used),
      .highest_prio (highest_prio),
      .any_ready    (any_ready)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         os_running_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            os_running_ff <= csr_wr_data;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff   <= req_operation;
         s1_prio_ff <= req_target_self ? req_current_prio : req_target_prio;
         s1_cur_ff  <= req_current_prio;
      end
      if (advance) begin
         rsp_status_ff  <= status;
         rsp_resched_ff <= reschedule;
         rsp_high_ff    <= highest_prio;
         rsp_any_ff     <= any_ready;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_reschedule   = rsp_resched_ff;
   assign rsp_highest_prio = rsp_high_ff;
   assign rsp_any_ready    = rsp_any_ff;

endmodule

// ===== hw/rtl/rbps_ready_map.sv =====
`timescale 1ns / 1ps
// Slot-used flags and ready bitmap, their update, and the two-level priority encode.
// Depends on rbps_pkg.
module rbps_ready_map (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  commit,
   input  rbps_pkg::slot_type     slot,
   input  rbps_pkg::map_ctrl_type ctrl,
   output logic                  slot_used,
   output rbps_pkg::prio_type     highest_prio,
   output logic                  any_ready
);
   import rbps_pkg::*;

   logic [NUM_SLOTS-1:0] used_ff;
   logic [NUM_SLOTS-1:0] used_in;
   logic [NUM_SLOTS-1:0] ready_ff;
   logic [NUM_SLOTS-1:0] ready_in;
   row_bits_type         groups;
   row_bits_type         hi_row_bits;
   row_idx_type          hi_row;
   row_idx_type          hi_col;

   assign slot_used = used_ff[slot];

   always_comb begin
      used_in  = used_ff;
      ready_in = ready_ff;
      if (ctrl.set_used) begin
         used_in[slot] = 1'b1;
      end
      if (ctrl.clr_used) begin
         used_in[slot] = 1'b0;
      end
      if (ctrl.set_ready) begin
         ready_in[slot] = 1'b1;
      end
      if (ctrl.clr_ready) begin
         ready_in[slot] = 1'b0;
      end
   end

   // The group map is the OR of each row of the updated bitmap.
   always_comb begin
      for (int r = 0; r < ROW_WIDTH; r++) begin
         groups[r] = |ready_in[r*ROW_WIDTH +: ROW_WIDTH];
      end
   end

   assign any_ready   = |groups;
   assign hi_row      = lowest_set(groups);
   assign hi_row_bits = ready_in[int'(hi_row)*ROW_WIDTH +: ROW_WIDTH];
   assign hi_col      = lowest_set(hi_row_bits);

   always_comb begin
      if (any_ready) begin
         highest_prio = PRIO_W'(int'(hi_row) * ROW_WIDTH + int'(hi_col));
      end else begin
         highest_prio = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         ready_ff <= '0;
      end else if (commit) begin
         used_ff  <= used_in;
         ready_ff <= ready_in;
      end
   end

endmodule

// ===== hw/rtl/rbps_decode.sv =====
`timescale 1ns / 1ps
// Operation decode: status, reschedule request and the update sent to the ready map.
// Depends on rbps_pkg.
module rbps_decode (
   input  rbps_pkg::op_type       operation,
   input  rbps_pkg::prio_type     prio,
   input  rbps_pkg::prio_type     current_prio,
   input  logic                  os_running,
   input  logic                  slot_used,
   input  rbps_pkg::prio_type     highest_prio,
   input  logic                  any_ready,
   output rbps_pkg::slot_type     slot,
   output rbps_pkg::map_ctrl_type ctrl,
   output rbps_pkg::status_type   status,
   output logic                  reschedule
);
   import rbps_pkg::*;

   logic in_range;
   logic exists;

   assign slot     = prio[SLOT_W-1:0];
   assign in_range = {1'b0, prio} < (PRIO_W + 1)'(NUM_SLOTS);
   assign exists   = in_range && slot_used;

   always_comb begin
      ctrl       = '0;
      status     = ST_OK;
      reschedule = 1'b0;
      unique case (operation)
         OP_CREATE: begin
            if (exists || !in_range) begin
               status = ST_TAKEN;
            end else begin
               ctrl.set_used  = 1'b1;
               ctrl.set_ready = 1'b1;
               reschedule     = os_running && (current_prio > prio);
            end
         end
         OP_RESUME: begin
            if (!exists) begin
               status = ST_NONE;
            end else begin
               ctrl.set_ready = 1'b1;
               reschedule     = prio < current_prio;
            end
         end
         OP_PEND: begin
            if (!exists) begin
               status = ST_NONE;
            end else begin
               ctrl.clr_ready = 1'b1;
               reschedule     = prio == current_prio;
            end
         end
         OP_DELETE: begin
            if (!exists) begin
               status = ST_NONE;
            end else begin
               ctrl.clr_ready = 1'b1;
               ctrl.clr_used  = 1'b1;
               reschedule     = prio == current_prio;
            end
         end
         OP_CHECK: begin
            reschedule = os_running && any_ready && (highest_prio != current_prio);
         end
         default: begin
         end
      endcase
   end

endmodule
